// ===== hdl/tlrc_pkg.sv =====
// Package for the thick line rasterizer: sizes, codes and word layouts.
`default_nettype none
package tlrc_pkg;

	localparam int COORD_BITS = 13;
	localparam int VIEW_MAX   = 2048;

	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int ERR_BITS   = COORD_BITS + 3;
	localparam int LOCAL_BITS = (COORD_BITS > 12 ? COORD_BITS : 12) + 1;

	localparam int ORIGIN_BITS = 11;
	localparam int VIEW_BITS   = 12;
	localparam int CFG_BITS    = 12;
	localparam int CFG_IDX_BITS = 2;

	localparam int PIX_BITS   = 11;
	localparam int ADDR_BITS  = 22;
	localparam int COLOR_BITS = 16;
	localparam int THICK_BITS = 8;
	localparam int HALF_BITS  = 7;

	// Input word layout
	localparam int IN_FIELD_BITS = 4 * COORD_BITS + COLOR_BITS + THICK_BITS;
	localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int IN_SC_LO = 0;
	localparam int IN_SR_LO = IN_SC_LO + COORD_BITS;
	localparam int IN_EC_LO = IN_SR_LO + COORD_BITS;
	localparam int IN_ER_LO = IN_EC_LO + COORD_BITS;
	localparam int IN_PC_LO = IN_ER_LO + COORD_BITS;
	localparam int IN_PT_LO = IN_PC_LO + COLOR_BITS;

	// Output word layout
	localparam int OUT_FIELD_BITS = 3 * PIX_BITS + ADDR_BITS + COLOR_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_COL_LO  = 0;
	localparam int OUT_LOW_LO  = OUT_COL_LO + PIX_BITS;
	localparam int OUT_HIGH_LO = OUT_LOW_LO + PIX_BITS;
	localparam int OUT_ADDR_LO = OUT_HIGH_LO + PIX_BITS;
	localparam int OUT_CLR_LO  = OUT_ADDR_LO + ADDR_BITS;

	localparam logic [VIEW_BITS-1:0] VIEW_LIMIT = VIEW_BITS'(VIEW_MAX);

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_WIDTH    = 2'd2,
		REG_HEIGHT   = 2'd3
	} cfg_idx_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage
`default_nettype wire

// ===== hdl/thick_line_rasterizer_clip.sv =====
// Top level of the thick line rasterizer with viewport clipping.
`default_nettype none
// Usage
//   s_axis words carry a command: tuser[0] is the opcode (start or step),
//   tdata holds the endpoints, pen colour and thickness (used on start).
//   A start word loads and arms a line and gives no output word. Each step
//   word on an armed line gives one span word on m_axis; a step with no
//   armed line is dropped. m_axis tlast marks the endpoint span, tuser[0]
//   says the centre pixel is visible (a hidden span has zero column, rows
//   and address).
//   The cfg port sets viewport origin and size; write it only while idle.
// Timing
//   One word per clock in both directions while m_tready is high. A step word
//   loads stage one (Bresenham step and clip); stage two, row*stride+column
//   in one 11x12 multiplier, then registers the span that m_axis offers.
// Reset
//   arst_n clears the pipeline, drops any armed line and restores 320x240 at 0,0.
// Stall
//   When m_tready is low the output word holds and the first stage keeps
//   accepting until it too is full; s_tready then falls until the receiver
//   takes the waiting word.
module thick_line_rasterizer_clip (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// cfg: write enable, register index, data
	input  wire                                   cfg_wen,
	input  wire  [tlrc_pkg::CFG_IDX_BITS-1:0]     cfg_addr,
	input  wire  [tlrc_pkg::CFG_BITS-1:0]         cfg_wdata,
	// tdata from bit 0: start_col, start_row, end_col, end_row,
	// pen_color, pen_thickness, zero fill
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [tlrc_pkg::IN_DATA_BITS-1:0]     s_tdata,
	// tuser: opcode
	input  wire  [0:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	// tdata from bit 0: span_col, span_row_low, span_row_high, span_addr,
	// span_color, zero fill
	output logic [tlrc_pkg::OUT_DATA_BITS-1:0]    m_tdata,
	// tuser: span_visible
	output logic [0:0]                            m_tuser,
	output logic                                  m_tlast
);
	import tlrc_pkg::*;

	// Viewport registers
	logic [ORIGIN_BITS-1:0] ox_q, oy_q;
	logic [VIEW_BITS-1:0]   w_q, h_q;
	logic [VIEW_BITS-1:0]   cfg_view;

	// Line state
	coord_t                 cur_col_q, cur_row_q, goal_col_q, goal_row_q;
	logic [DELTA_BITS-1:0]  dc_q, dr_q;
	logic [1:0]             dirs_q;
	logic signed [ERR_BITS-1:0] err_q;
	logic [COLOR_BITS-1:0]  color_q;
	logic [HALF_BITS-1:0]   half_q;
	logic                   active_q;

	// Pipeline
	logic                   v_s1;
	logic [PIX_BITS-1:0]    col_s1, lo_s1, hi_s1;
	logic [COLOR_BITS-1:0]  color_s1;
	logic                   vis_s1, last_s1;

	logic                   v_s2;
	logic [PIX_BITS-1:0]    col_s2, lo_s2, hi_s2;
	logic [ADDR_BITS-1:0]   addr_s2;
	logic [COLOR_BITS-1:0]  color_s2;
	logic                   vis_s2, last_s2;

	logic en1, en2, accept, is_start, is_step;

	// Input fields
	coord_t                 x0, y0, x1, y1;
	logic [COLOR_BITS-1:0]  pen_color;
	logic [THICK_BITS-1:0]  pen_thick;

	// Start set-up
	logic signed [DELTA_BITS-1:0] dx_raw, dy_raw;
	logic [DELTA_BITS-1:0]  dc_new, dr_new;
	logic [HALF_BITS-1:0]   half_new;

	// Step logic
	logic signed [LOCAL_BITS-1:0] lx, ly, wl, hl, a_row, b_row, hm1;
	logic                   vis, last;
	logic [PIX_BITS-1:0]    col_n, lo_n, hi_n;
	logic signed [ERR_BITS-1:0] e2, dc_e, dr_e, err_n;
	logic                   mv_col, mv_row;

	logic [PIX_BITS+VIEW_BITS-1:0] prod;

	// Handshake: stage 2 frees on take, stage 1 frees when it can move on
	assign en2      = !v_s2 || m_tready;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign accept   = s_tvalid && en1;
	assign is_start = accept && (s_tuser[0] == OP_START);
	assign is_step  = accept && (s_tuser[0] == OP_STEP) && active_q;

	assign x0        = s_tdata[IN_SC_LO +: COORD_BITS];
	assign y0        = s_tdata[IN_SR_LO +: COORD_BITS];
	assign x1        = s_tdata[IN_EC_LO +: COORD_BITS];
	assign y1        = s_tdata[IN_ER_LO +: COORD_BITS];
	assign pen_color = s_tdata[IN_PC_LO +: COLOR_BITS];
	assign pen_thick = s_tdata[IN_PT_LO +: THICK_BITS];

	// Width and height above the limit act as the limit
	assign cfg_view = (cfg_wdata > VIEW_LIMIT) ? VIEW_LIMIT : cfg_wdata;

	always_comb begin
		dx_raw   = DELTA_BITS'(x1) - DELTA_BITS'(x0);
		dy_raw   = DELTA_BITS'(y1) - DELTA_BITS'(y0);
		dc_new   = dx_raw[DELTA_BITS-1] ? DELTA_BITS'(-dx_raw) : DELTA_BITS'(dx_raw);
		dr_new   = dy_raw[DELTA_BITS-1] ? DELTA_BITS'(-dy_raw) : DELTA_BITS'(dy_raw);
		half_new = (pen_thick == '0) ? '0 : HALF_BITS'((pen_thick - 1'b1) >> 1);
	end

	// Clip the current point and grow the vertical span around it
	always_comb begin
		lx    = LOCAL_BITS'(cur_col_q) - $signed(LOCAL_BITS'(ox_q));
		ly    = LOCAL_BITS'(cur_row_q) - $signed(LOCAL_BITS'(oy_q));
		wl    = $signed(LOCAL_BITS'(w_q));
		hl    = $signed(LOCAL_BITS'(h_q));
		hm1   = hl - LOCAL_BITS'(1);
		vis   = !lx[LOCAL_BITS-1] && (lx < wl) && !ly[LOCAL_BITS-1] && (ly < hl);
		last  = (cur_col_q == goal_col_q) && (cur_row_q == goal_row_q);
		a_row = ly - $signed(LOCAL_BITS'(half_q));
		b_row = ly + $signed(LOCAL_BITS'(half_q));
		if (a_row[LOCAL_BITS-1]) begin
			a_row = '0;
		end
		if (b_row > hm1) begin
			b_row = hm1;
		end
		col_n = vis ? lx[PIX_BITS-1:0]    : '0;
		lo_n  = vis ? a_row[PIX_BITS-1:0] : '0;
		hi_n  = vis ? b_row[PIX_BITS-1:0] : '0;
	end

	// One Bresenham step; both tests use the same doubled error
	always_comb begin
		e2     = err_q <<< 1;
		dc_e   = $signed(ERR_BITS'(dc_q));
		dr_e   = $signed(ERR_BITS'(dr_q));
		mv_col = e2 > -dr_e;
		mv_row = e2 < dc_e;
		err_n  = err_q;
		if (mv_col) begin
			err_n = err_n - dr_e;
		end
		if (mv_row) begin
			err_n = err_n + dc_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q <= '0;
			oy_q <= '0;
			w_q  <= VIEW_BITS'(320);
			h_q  <= VIEW_BITS'(240);
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_ORIGIN_X: ox_q <= cfg_wdata[ORIGIN_BITS-1:0];
				REG_ORIGIN_Y: oy_q <= cfg_wdata[ORIGIN_BITS-1:0];
				REG_WIDTH:    w_q  <= cfg_view;
				REG_HEIGHT:   h_q  <= cfg_view;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			goal_col_q <= '0;
			goal_row_q <= '0;
			dc_q       <= '0;
			dr_q       <= '0;
			dirs_q     <= '0;
			err_q      <= '0;
			color_q    <= '0;
			half_q     <= '0;
			active_q   <= 1'b0;
		end else if (is_start) begin
			// Replace whatever line is in progress
			cur_col_q  <= x0;
			cur_row_q  <= y0;
			goal_col_q <= x1;
			goal_row_q <= y1;
			dc_q       <= dc_new;
			dr_q       <= dr_new;
			dirs_q     <= {!(y0 < y1), !(x0 < x1)};
			err_q      <= $signed(ERR_BITS'(dc_new)) - $signed(ERR_BITS'(dr_new));
			color_q    <= pen_color;
			half_q     <= half_new;
			active_q   <= 1'b1;
		end else if (is_step) begin
			if (last) begin
				active_q <= 1'b0;
			end else begin
				err_q <= err_n;
				if (mv_col) begin
					cur_col_q <= dirs_q[0] ? cur_col_q - 1'b1 : cur_col_q + 1'b1;
				end
				if (mv_row) begin
					cur_row_q <= dirs_q[1] ? cur_row_q - 1'b1 : cur_row_q + 1'b1;
				end
			end
		end
	end

	// Stage 1: clipped span of the current point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= is_step;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && is_step) begin
			col_s1   <= col_n;
			lo_s1    <= lo_n;
			hi_s1    <= hi_n;
			color_s1 <= color_q;
			vis_s1   <= vis;
			last_s1  <= last;
		end
	end

	// Stage 2: framebuffer index; hidden spans carry zero row and column
	assign prod = (PIX_BITS+VIEW_BITS)'(lo_s1) * (PIX_BITS+VIEW_BITS)'(w_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			col_s2   <= col_s1;
			lo_s2    <= lo_s1;
			hi_s2    <= hi_s1;
			addr_s2  <= ADDR_BITS'(prod + (PIX_BITS+VIEW_BITS)'(col_s1));
			color_s2 <= color_s1;
			vis_s2   <= vis_s1;
			last_s2  <= last_s1;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = vis_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = OUT_DATA_BITS'({color_s2, addr_s2, hi_s2, lo_s2, col_s2});

endmodule
`default_nettype wire

// ===== hdl/tlrc_checker.sv =====
// Port-level checker for the thick line rasterizer, bound to the top level.
`default_nettype none
module tlrc_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                m_tvalid,
	input wire                                m_tready,
	input wire [tlrc_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input wire [0:0]                          m_tuser,
	input wire                                m_tlast
);
	import tlrc_pkg::*;

	// In the cycle after reset is sampled low no span word may show
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("span word valid during reset");

	// A stalled span word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled span word changed");

	// A hidden span carries zero column, rows and address
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[OUT_CLR_LO-1:0] == '0)
		else $error("hidden span with nonzero position");

	// A visible span never runs upwards
	a_rows_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[OUT_LOW_LO +: PIX_BITS] <= m_tdata[OUT_HIGH_LO +: PIX_BITS])
		else $error("span low row above high row");

endmodule

bind thick_line_rasterizer_clip tlrc_checker u_tlrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
